FILE: rtl/core/complex_arithmetic_unit_macros.svh
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cau_pkg.sv
// package: constants, types and helpers of the complex arithmetic unit
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int MAX_EXPONENT = 15;

    localparam int DATA_W = 32;
    localparam int INT_W  = 8;
    localparam int EXP_W  = 4;
    localparam int CMD_W  = 4;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int REM_W  = PROD_W + 1;
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int SQRT_STEPS = DATA_W;
    localparam int POW_W  = $clog2(MAX_EXPONENT + 1);
    localparam int K_W    = 3;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 2 * DATA_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_MUL    = 4'd2,
        CMD_DIV    = 4'd3,
        CMD_SCALE  = 4'd4,
        CMD_RDIV   = 4'd5,
        CMD_ADDINT = 4'd6,
        CMD_SUBINT = 4'd7,
        CMD_POW    = 4'd8,
        CMD_MOD    = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        TGT_RE  = 2'd0,
        TGT_IM  = 2'd1,
        TGT_DEN = 2'd2
    } t_tgt;

    // one multiply-accumulate step of the sequencer
    typedef struct packed {
        logic signed [DATA_W-1:0] ma;
        logic signed [DATA_W-1:0] mb;
        t_tgt                     tgt;
        logic                     sub;
        logic                     last;
    } t_mstep;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] den;
    } t_ds_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
        logic              ov;
    } t_ds_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ov;
    } t_sat;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // saturate a wide signed value to the data width
    function automatic t_sat sat_data(input logic signed [ACC_W-1:0] x);
        t_sat r;
        r.value = x[DATA_W-1:0];
        r.ov    = 1'b0;
        if (x > SAT_HI) begin
            r.value = SAT_HI[DATA_W-1:0];
            r.ov    = 1'b1;
        end else if (x < SAT_LO) begin
            r.value = SAT_LO[DATA_W-1:0];
            r.ov    = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/cau_divsqrt.sv
// shared restoring divider and square-root unit, one result bit per cycle
`timescale 1ns / 1ps

module cau_divsqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cau_pkg::t_ds_req i_req,
    output cau_pkg::t_ds_rsp o_rsp
);
    import cau_pkg::*;

    logic                    r_busy;
    logic                    r_sqrt;
    logic                    r_neg;
    logic [DVD_W-1:0]        r_dvd;
    logic [REM_W-1:0]        r_rem;
    logic [PROD_W-1:0]       r_den;
    logic [DATA_W:0]         r_q;
    logic                    r_qov;
    logic [STEP_W-1:0]       r_step;
    logic                    r_done;
    logic [DATA_W-1:0]       r_val;
    logic                    r_ov;

    logic [REM_W-1:0]        w_rem_sh;
    logic [REM_W-1:0]        w_sub;
    logic                    w_ge;
    logic [REM_W-1:0]        n_rem;
    logic [DATA_W:0]         n_q;
    logic                    n_qov;
    logic                    w_last;
    logic [DATA_W:0]         w_lim;
    logic                    w_over;
    logic [DATA_W-1:0]       w_val;

    // one compare-subtract step, shared by both modes
    always_comb begin
        if (r_sqrt) begin
            w_rem_sh = {r_rem[REM_W-3:0], r_dvd[DVD_W-1 -: 2]};
            w_sub    = REM_W'({r_q[DATA_W-1:0], 2'b01});
        end else begin
            w_rem_sh = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
            w_sub    = REM_W'(r_den);
        end
        w_ge   = (w_rem_sh >= w_sub);
        n_rem  = w_ge ? (w_rem_sh - w_sub) : w_rem_sh;
        n_q    = {r_q[DATA_W-1:0], w_ge};
        n_qov  = r_qov | (!r_sqrt & r_q[DATA_W]);
        w_last = r_sqrt ? (r_step == STEP_W'(SQRT_STEPS - 1))
                        : (r_step == STEP_W'(DVD_W - 1));
    end

    // final clamp and sign
    always_comb begin
        w_lim = r_neg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
        if (r_sqrt) begin
            w_over = n_q[DATA_W] | n_q[DATA_W-1];
            w_val  = w_over ? {1'b0, {(DATA_W-1){1'b1}}} : n_q[DATA_W-1:0];
        end else begin
            w_over = n_qov | (n_q > w_lim);
            if (w_over) begin
                w_val = w_lim[DATA_W-1:0];
            end else begin
                w_val = r_neg ? (~n_q[DATA_W-1:0] + 1'b1) : n_q[DATA_W-1:0];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt_mode;
            r_neg  <= i_req.neg;
            r_dvd  <= {i_req.mag, {FRAC_BITS{1'b0}}};
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_q    <= '0;
            r_qov  <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_dvd  <= r_sqrt ? (r_dvd << 2) : (r_dvd << 1);
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_qov  <= n_qov;
            r_step <= r_step + 1'b1;
            if (w_last) begin
                r_val <= w_val;
                r_ov  <= w_over;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;
    assign o_rsp.ov    = r_ov;

endmodule

FILE: rtl/core/complex_arithmetic_unit.sv
// top level: complex-number alu in signed fixed point
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_macros.svh"

// Complex ALU on signed Q8.24 operands, one command at a time. Add, subtract and the
// integer add/subtract need no multiplier; multiply and scale take four products
// through the one 32x32 multiplier; power repeats that for each of its exponent-1
// multiplications; modulus takes two products, then a 32-step square root; divide and
// real-by-complex are set by two 88-step restoring divisions in the shared divide/root
// unit, one quotient bit per cycle. The input is not ready until the current result has
// been moved to the output register. Saturation sets the overflow flag; a zero divisor
// returns zero with the div_zero flag.
module complex_arithmetic_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // a_re, a_im, b_re, b_im, real_scalar, int_operand, exponent, zero pad
    input  logic [cau_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // command
    input  logic [cau_pkg::CMD_W-1:0]       i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // res_re, res_im
    output logic [cau_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // div_zero, overflow
    output logic [1:0]                      o_m_tuser
);
    import cau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_POST = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // input fields
    logic signed [DATA_W-1:0] w_a_re, w_a_im, w_b_re, w_b_im, w_scalar;
    logic signed [INT_W-1:0]  w_int;
    logic [EXP_W-1:0]         w_exp;
    t_cmd                     w_cmd;
    logic [POW_W-1:0]         w_exp_eff;
    logic                     w_accept;

    assign w_a_re   = $signed(i_s_tdata[DATA_W-1:0]);
    assign w_a_im   = $signed(i_s_tdata[2*DATA_W-1:DATA_W]);
    assign w_b_re   = $signed(i_s_tdata[3*DATA_W-1:2*DATA_W]);
    assign w_b_im   = $signed(i_s_tdata[4*DATA_W-1:3*DATA_W]);
    assign w_scalar = $signed(i_s_tdata[5*DATA_W-1:4*DATA_W]);
    assign w_int    = $signed(i_s_tdata[5*DATA_W+INT_W-1:5*DATA_W]);
    assign w_exp    = i_s_tdata[5*DATA_W+INT_W+EXP_W-1:5*DATA_W+INT_W];
    assign w_cmd    = t_cmd'(i_s_tuser);
    assign w_exp_eff = (int'(w_exp) > MAX_EXPONENT) ? POW_W'(MAX_EXPONENT) : POW_W'(w_exp);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // working registers
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_xr, r_xi, r_yr, r_yi;
    logic [K_W-1:0]           r_k;
    logic [POW_W-1:0]         r_pow;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic [PROD_W-1:0]        r_den;
    logic                     r_part;
    logic [DATA_W-1:0]        r_res_re, r_res_im;
    logic                     r_ov, r_dz;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_re, r_out_im;
    logic                     r_out_dz, r_out_ov;

    // direct results for the commands that need no multiplier
    logic signed [ACC_W-1:0] w_sum_re, w_sum_im, w_int_sh;
    t_sat                    w_dre, w_dim;

    assign w_int_sh = ACC_W'(w_int) <<< FRAC_BITS;

    always_comb begin
        w_sum_re = '0;
        w_sum_im = '0;
        unique case (w_cmd)
            CMD_ADD: begin
                w_sum_re = ACC_W'(w_a_re) + ACC_W'(w_b_re);
                w_sum_im = ACC_W'(w_a_im) + ACC_W'(w_b_im);
            end
            CMD_SUB: begin
                w_sum_re = ACC_W'(w_a_re) - ACC_W'(w_b_re);
                w_sum_im = ACC_W'(w_a_im) - ACC_W'(w_b_im);
            end
            CMD_ADDINT: begin
                w_sum_re = ACC_W'(w_a_re) + w_int_sh;
                w_sum_im = ACC_W'(w_a_im);
            end
            CMD_SUBINT: begin
                w_sum_re = ACC_W'(w_a_re) - w_int_sh;
                w_sum_im = ACC_W'(w_a_im);
            end
            CMD_POW: begin
                w_sum_re = ACC_W'(w_a_re);
                w_sum_im = ACC_W'(w_a_im);
            end
            default: begin
                w_sum_re = '0;
                w_sum_im = '0;
            end
        endcase
        w_dre = sat_data(w_sum_re);
        w_dim = sat_data(w_sum_im);
    end

    // multiply step table
    t_mstep w_step;
    logic   w_cmul;
    logic   w_divcls;

    assign w_cmul   = (r_cmd == CMD_MUL) || (r_cmd == CMD_SCALE) || (r_cmd == CMD_POW);
    assign w_divcls = (r_cmd == CMD_DIV) || (r_cmd == CMD_RDIV);

    always_comb begin
        w_step = '{ma: r_xr, mb: r_yr, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
        unique case (r_cmd)
            CMD_MUL, CMD_SCALE, CMD_POW: begin
                unique case (r_k)
                    3'd0: w_step = '{ma: r_xr, mb: r_yr, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
                    3'd1: w_step = '{ma: r_xi, mb: r_yi, tgt: TGT_RE, sub: 1'b1, last: 1'b0};
                    3'd2: w_step = '{ma: r_yr, mb: r_xi, tgt: TGT_IM, sub: 1'b0, last: 1'b0};
                    default: w_step = '{ma: r_xr, mb: r_yi, tgt: TGT_IM, sub: 1'b0, last: 1'b1};
                endcase
            end
            CMD_DIV: begin
                unique case (r_k)
                    3'd0: w_step = '{ma: r_yr, mb: r_yr, tgt: TGT_DEN, sub: 1'b0, last: 1'b0};
                    3'd1: w_step = '{ma: r_yi, mb: r_yi, tgt: TGT_DEN, sub: 1'b0, last: 1'b0};
                    3'd2: w_step = '{ma: r_xr, mb: r_yr, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
                    3'd3: w_step = '{ma: r_xi, mb: r_yi, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
                    3'd4: w_step = '{ma: r_xi, mb: r_yr, tgt: TGT_IM, sub: 1'b0, last: 1'b0};
                    default: w_step = '{ma: r_xr, mb: r_yi, tgt: TGT_IM, sub: 1'b1, last: 1'b1};
                endcase
            end
            CMD_RDIV: begin
                unique case (r_k)
                    3'd0: w_step = '{ma: r_yr, mb: r_yr, tgt: TGT_DEN, sub: 1'b0, last: 1'b0};
                    3'd1: w_step = '{ma: r_yi, mb: r_yi, tgt: TGT_DEN, sub: 1'b0, last: 1'b0};
                    3'd2: w_step = '{ma: r_xr, mb: r_yr, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
                    default: w_step = '{ma: r_xr, mb: r_yi, tgt: TGT_IM, sub: 1'b1, last: 1'b1};
                endcase
            end
            CMD_MOD: begin
                unique case (r_k)
                    3'd0: w_step = '{ma: r_xr, mb: r_xr, tgt: TGT_RE, sub: 1'b0, last: 1'b0};
                    default: w_step = '{ma: r_xi, mb: r_xi, tgt: TGT_RE, sub: 1'b0, last: 1'b1};
                endcase
            end
            default: begin
                w_step = '{ma: r_xr, mb: r_yr, tgt: TGT_RE, sub: 1'b0, last: 1'b1};
            end
        endcase
    end

    // product extended to accumulator width
    logic signed [ACC_W-1:0] w_pext;
    assign w_pext = ACC_W'(r_prod);

    // scaled and saturated complex product
    logic signed [ACC_W-1:0] w_sh_re, w_sh_im;
    t_sat                    w_cre, w_cim;

    assign w_sh_re = r_acc_re >>> FRAC_BITS;
    assign w_sh_im = r_acc_im >>> FRAC_BITS;
    assign w_cre   = sat_data(w_sh_re);
    assign w_cim   = sat_data(w_sh_im);

    // divide / root requests
    t_ds_req                 w_ds_req;
    t_ds_rsp                 w_ds_rsp;
    logic signed [ACC_W-1:0] w_num;
    logic signed [ACC_W-1:0] w_num_abs;

    // the second division is started from the divide phase and takes the imaginary part
    assign w_num     = (r_state == S_DIV) ? r_acc_im : r_acc_re;
    assign w_num_abs = w_num[ACC_W-1] ? -w_num : w_num;

    always_comb begin
        w_ds_req.sqrt_mode = (r_cmd == CMD_MOD);
        w_ds_req.neg       = (r_cmd == CMD_MOD) ? 1'b0 : w_num[ACC_W-1];
        w_ds_req.mag       = w_num_abs[PROD_W-1:0];
        w_ds_req.den       = r_den;
        w_ds_req.start     = 1'b0;
        if (r_state == S_POST) begin
            w_ds_req.start = (r_cmd == CMD_MOD) || (w_divcls && (r_den != '0));
        end else if (r_state == S_DIV) begin
            w_ds_req.start = w_ds_rsp.done && w_divcls && !r_part;
        end
    end

    cau_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ds_req),
        .o_rsp   (w_ds_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_MUL || w_cmd == CMD_DIV || w_cmd == CMD_SCALE ||
                        w_cmd == CMD_RDIV || w_cmd == CMD_MOD ||
                        (w_cmd == CMD_POW && w_exp_eff > POW_W'(1))) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = w_step.last ? S_POST : S_MUL;
            S_POST: begin
                if (w_ds_req.start) begin
                    n_state = S_DIV;
                end else if (r_cmd == CMD_POW && r_pow > POW_W'(1)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (w_ds_rsp.done && !w_ds_req.start) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd    <= w_cmd;
                    r_k      <= '0;
                    r_part   <= 1'b0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    r_den    <= '0;
                    r_pow    <= w_exp_eff - 1'b1;
                    r_dz     <= 1'b0;
                    r_ov     <= w_dre.ov | w_dim.ov;
                    r_res_re <= w_dre.value;
                    r_res_im <= w_dim.value;
                    if (w_cmd == CMD_RDIV) begin
                        r_xr <= w_scalar;
                        r_xi <= '0;
                    end else begin
                        r_xr <= w_a_re;
                        r_xi <= w_a_im;
                    end
                    if (w_cmd == CMD_SCALE) begin
                        r_yr <= w_scalar;
                        r_yi <= '0;
                    end else if (w_cmd == CMD_POW) begin
                        r_yr <= w_a_re;
                        r_yi <= w_a_im;
                    end else begin
                        r_yr <= w_b_re;
                        r_yi <= w_b_im;
                    end
                end
            end
            S_MUL: begin
                r_prod <= w_step.ma * w_step.mb;
            end
            S_ACC: begin
                r_k <= r_k + 1'b1;
                unique case (w_step.tgt)
                    TGT_RE:  r_acc_re <= w_step.sub ? (r_acc_re - w_pext) : (r_acc_re + w_pext);
                    TGT_IM:  r_acc_im <= w_step.sub ? (r_acc_im - w_pext) : (r_acc_im + w_pext);
                    TGT_DEN: r_den    <= r_den + r_prod[PROD_W-1:0];
                    default: r_den    <= r_den;
                endcase
            end
            S_POST: begin
                if (w_cmul) begin
                    r_ov     <= r_ov | w_cre.ov | w_cim.ov;
                    r_res_re <= w_cre.value;
                    r_res_im <= w_cim.value;
                    // next power step starts from the saturated product
                    r_xr     <= $signed(w_cre.value);
                    r_xi     <= $signed(w_cim.value);
                    r_pow    <= r_pow - 1'b1;
                    r_k      <= '0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else if (w_divcls && r_den == '0) begin
                    r_dz     <= 1'b1;
                    r_res_re <= '0;
                    r_res_im <= '0;
                end
            end
            S_DIV: begin
                if (w_ds_rsp.done) begin
                    r_ov <= r_ov | w_ds_rsp.ov;
                    if (r_cmd == CMD_MOD) begin
                        r_res_re <= w_ds_rsp.value;
                        r_res_im <= '0;
                    end else if (!r_part) begin
                        r_res_re <= w_ds_rsp.value;
                        r_part   <= 1'b1;
                    end else begin
                        r_res_im <= w_ds_rsp.value;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    r_out_re <= r_res_re;
                    r_out_im <= r_res_im;
                    r_out_dz <= r_dz;
                    r_out_ov <= r_ov;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_im, r_out_re};
    assign o_m_tuser  = {r_out_ov, r_out_dz};

    // checks
    `CAU_ASSERT_IMPLY(a_dz_gives_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == '0 && !o_m_tuser[1], "div_zero result not zero")
    `CAU_ASSERT_IMPLY(a_ds_done_in_div, i_clk, i_rst_n, w_ds_rsp.done, r_state == S_DIV, "divide unit finished outside divide phase")
    `CAU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready, "ready right after a transfer")

endmodule

FILE: bench/testbench.sv
// testbench for the complex arithmetic unit: directed and random commands against a predictor
`timescale 1ns / 1ps

module testbench;
    import cau_pkg::*;

    localparam int               LIMIT_CYCLES = 2000000;
    localparam int               N_RANDOM     = 1400;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
    localparam logic [31:0]      Q_MAX        = 32'h7fffffff;
    localparam logic [31:0]      Q_MIN        = 32'h80000000;
    localparam logic [31:0]      Q_ONE        = 32'h01000000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic signed [31:0] ar, ai, br, bi, s;
        logic signed [7:0]  n;
        logic [3:0]         e;
    } t_op;

    typedef struct {
        logic [31:0] re, im;
        logic        dz, ov;
    } t_res;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [CMD_W-1:0]       i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic [1:0]             o_m_tuser;

    t_op  pending_ops[$];
    t_res expected_res[$];
    logic in_taken = 1'b0;
    logic failed = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   accepted_cnt = 0;
    int   cycle_cnt = 0;
    logic calm;

    complex_arithmetic_unit dut (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // no idling on either side over this window of transfers
    assign calm = (accepted_cnt >= 600) && (accepted_cnt < 900);

    // saturate to 32 bits signed
    function automatic logic [31:0] clip(input logic signed [127:0] x, inout logic ov);
        if (x > $signed({96'd0, Q_MAX})) begin
            ov = 1'b1;
            return Q_MAX;
        end
        if (x < -$signed(128'h80000000)) begin
            ov = 1'b1;
            return Q_MIN;
        end
        return x[31:0];
    endfunction

    // complex product in fixed point, floor shift then saturate
    function automatic void cplx_mul(input logic signed [31:0] ar, ai, br, bi,
                                     output logic signed [31:0] rr, ri, inout logic ov);
        logic signed [127:0] xr, xi, yr, yi;
        xr = ar; xi = ai; yr = br; yi = bi;
        rr = clip((xr * yr - xi * yi) >>> FRAC_BITS, ov);
        ri = clip((yr * xi + xr * yi) >>> FRAC_BITS, ov);
    endfunction

    // quotient scaled by 2^FRAC_BITS, truncated toward zero, saturated
    function automatic logic [31:0] fix_div(input logic signed [127:0] num,
                                            input logic [127:0] den, inout logic ov);
        logic        neg;
        logic [127:0] mag, q, lim;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = (mag << FRAC_BITS) / den;
        lim = neg ? {96'd0, Q_MIN} : {96'd0, Q_MAX};
        if (q > lim) begin
            ov = 1'b1;
            q  = lim;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // expected result of one command
    function automatic t_res alu_result(input t_op o);
        t_res r;
        logic signed [127:0] ar, ai, br, bi, s, sq;
        logic [127:0] den;
        logic [32:0]  root;
        logic signed [31:0] pr, pi, tr, ti;
        int k;
        ar = o.ar; ai = o.ai; br = o.br; bi = o.bi; s = o.s;
        r = '{re: '0, im: '0, dz: 1'b0, ov: 1'b0};
        den = br * br + bi * bi;
        case (o.cmd)
            CMD_ADD: begin
                r.re = clip(ar + br, r.ov);
                r.im = clip(ai + bi, r.ov);
            end
            CMD_SUB: begin
                r.re = clip(ar - br, r.ov);
                r.im = clip(ai - bi, r.ov);
            end
            CMD_MUL: begin
                cplx_mul(o.ar, o.ai, o.br, o.bi, pr, pi, r.ov);
                r.re = pr; r.im = pi;
            end
            CMD_SCALE: begin
                cplx_mul(o.ar, o.ai, o.s, 32'sd0, pr, pi, r.ov);
                r.re = pr; r.im = pi;
            end
            CMD_DIV, CMD_RDIV: begin
                if (den == 0) begin
                    r.dz = 1'b1;
                end else if (o.cmd == CMD_DIV) begin
                    r.re = fix_div(ar * br + ai * bi, den, r.ov);
                    r.im = fix_div(ai * br - ar * bi, den, r.ov);
                end else begin
                    r.re = fix_div(s * br, den, r.ov);
                    r.im = fix_div(-(s * bi), den, r.ov);
                end
            end
            CMD_ADDINT: begin
                r.re = clip(ar + ($signed({{120{o.n[7]}}, o.n}) <<< FRAC_BITS), r.ov);
                r.im = o.ai;
            end
            CMD_SUBINT: begin
                r.re = clip(ar - ($signed({{120{o.n[7]}}, o.n}) <<< FRAC_BITS), r.ov);
                r.im = o.ai;
            end
            CMD_POW: begin
                pr = o.ar; pi = o.ai;
                for (k = 1; k < ((o.e > MAX_EXPONENT) ? MAX_EXPONENT : o.e); k++) begin
                    cplx_mul(pr, pi, o.ar, o.ai, tr, ti, r.ov);
                    pr = tr; pi = ti;
                end
                r.re = pr; r.im = pi;
            end
            CMD_MOD: begin
                sq = ar * ar + ai * ai;
                root = '0;
                for (k = 32; k >= 0; k--) begin
                    if ($signed({95'd0, root | (33'd1 << k)}) ** 2 <= sq)
                        root = root | (33'd1 << k);
                end
                if (root > {1'b0, Q_MAX}) begin
                    r.ov = 1'b1;
                    root = {1'b0, Q_MAX};
                end
                r.re = root[31:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // operand value: mostly near unity, sometimes extremes or full range
    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'd0;
                    3: return 32'd1;
                    default: return 32'hffffffff;
                endcase
            end
            3:       return $urandom_range(0, 255) << FRAC_BITS;
            default: return $urandom_range(0, 32'h03ffffff) - 32'h02000000;
        endcase
    endfunction

    function automatic t_op mk(input logic [CMD_W-1:0] c, input logic [31:0] ar, ai, br, bi,
                               s, input logic [7:0] n, input logic [3:0] e);
        t_op o;
        o.cmd = c; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi; o.s = s; o.n = n; o.e = e;
        return o;
    endfunction

    // sender: next transfer offered at the falling edge
    always @(negedge i_clk) begin
        t_op o;
        if (i_rst_n && (!i_s_tvalid || in_taken)) begin
            if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
                o = pending_ops.pop_front();
                i_s_tdata  <= {4'd0, o.e, o.n, o.s, o.bi, o.br, o.ai, o.ar};
                i_s_tuser  <= o.cmd;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && accepted_cnt >= 150) begin
            hold_done  <= 1'b1;
            hold_cnt   <= 400;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_op  o;
        t_res want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("complex_arithmetic_unit verification failed");
            $finish;
        end
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            o = mk(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64],
                   i_s_tdata[127:96], i_s_tdata[159:128], i_s_tdata[167:160],
                   i_s_tdata[171:168]);
            expected_res.push_back(alu_result(o));
            accepted_cnt <= accepted_cnt + 1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_res.size() == 0) begin
                $error("result transfer with nothing expected");
                failed <= 1'b1;
            end else begin
                want = expected_res.pop_front();
                if (o_m_tdata[31:0] !== want.re) begin
                    $error("res_re expected %h got %h", want.re, o_m_tdata[31:0]);
                    failed <= 1'b1;
                end
                if (o_m_tdata[63:32] !== want.im) begin
                    $error("res_im expected %h got %h", want.im, o_m_tdata[63:32]);
                    failed <= 1'b1;
                end
                if (o_m_tuser[0] !== want.dz) begin
                    $error("div_zero expected %b got %b", want.dz, o_m_tuser[0]);
                    failed <= 1'b1;
                end
                if (o_m_tuser[1] !== want.ov) begin
                    $error("overflow expected %b got %b", want.ov, o_m_tuser[1]);
                    failed <= 1'b1;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          i;
        logic [3:0]  c;
        logic [31:0] br, bi;
        // directed: extremes, every command, zero divisors, power corners, spare codes
        pending_ops.push_back(mk(CMD_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0));
        pending_ops.push_back(mk(CMD_ADD, Q_ONE, 32'd5, 32'hffffffff, 32'd7, 0, 0, 0));
        pending_ops.push_back(mk(CMD_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 0, 0, 0));
        pending_ops.push_back(mk(CMD_SUB, 32'h12345678, 0, 32'h02000000, 1, 0, 0, 0));
        pending_ops.push_back(mk(CMD_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0));
        pending_ops.push_back(mk(CMD_MUL, 32'h01800000, 32'hff000001, Q_ONE, 32'h00400000,
                                 0, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, Q_ONE, Q_ONE, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, Q_MAX, Q_MIN, 32'd1, 0, 0, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, 32'h03000000, 32'hfe000000, Q_ONE, Q_ONE, 0, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0));
        pending_ops.push_back(mk(CMD_SCALE, Q_MAX, Q_MIN, 0, 0, Q_MIN, 0, 0));
        pending_ops.push_back(mk(CMD_SCALE, 32'h01800000, 32'hffc00000, 0, 0, 32'h02000000,
                                 0, 0));
        pending_ops.push_back(mk(CMD_RDIV, 0, 0, 0, 0, Q_ONE, 0, 0));
        pending_ops.push_back(mk(CMD_RDIV, 0, 0, 32'd1, 32'hffffffff, Q_MIN, 0, 0));
        pending_ops.push_back(mk(CMD_RDIV, 0, 0, 32'h02000000, 32'h01000000, Q_ONE, 0, 0));
        pending_ops.push_back(mk(CMD_ADDINT, Q_MAX, Q_MIN, 0, 0, 0, 8'h7f, 0));
        pending_ops.push_back(mk(CMD_ADDINT, Q_MIN, 3, 0, 0, 0, 8'h80, 0));
        pending_ops.push_back(mk(CMD_SUBINT, Q_MIN, Q_MAX, 0, 0, 0, 8'h7f, 0));
        pending_ops.push_back(mk(CMD_SUBINT, Q_MAX, 0, 0, 0, 0, 8'h80, 0));
        pending_ops.push_back(mk(CMD_POW, 32'h01234567, 32'h89abcdef, 0, 0, 0, 0, 4'd0));
        pending_ops.push_back(mk(CMD_POW, Q_MIN, Q_MAX, 0, 0, 0, 0, 4'd1));
        pending_ops.push_back(mk(CMD_POW, 32'h01100000, 32'h00200000, 0, 0, 0, 0, 4'd15));
        pending_ops.push_back(mk(CMD_POW, 32'h04000000, 32'hfd000000, 0, 0, 0, 0, 4'd9));
        pending_ops.push_back(mk(CMD_MOD, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(CMD_MOD, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(CMD_SPARE_LO, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 8'hff,
                                 4'hf));
        pending_ops.push_back(mk(CMD_SPARE_HI, Q_MIN, 1, 2, 3, 4, 8'h55, 4'ha));
        // random commands, now and then a zero divisor
        for (i = 0; i < N_RANDOM; i++) begin
            c  = ($urandom_range(0, 99) < 3) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            br = pick_val();
            bi = pick_val();
            if ((c == CMD_DIV || c == CMD_RDIV) && $urandom_range(0, 9) == 0) begin
                br = 0;
                bi = 0;
            end
            pending_ops.push_back(mk(c, pick_val(), pick_val(), br, bi, pick_val(),
                                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending_ops.size() > 0 || i_s_tvalid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (!failed)
            $display("complex_arithmetic_unit verification clean");
        else
            $display("complex_arithmetic_unit verification failed");
        $finish;
    end

endmodule
